// ===== rtl/core/moving_average_presence_detector_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the moving average presence detector
// Shared concurrent assertion forms; ASSERT_OFF compiles them out.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_PRESENCE_DETECTOR_ASSERT_SVH
`define MOVING_AVERAGE_PRESENCE_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MAPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mapd: same-cycle check failed");
// next-cycle implication
`define MAPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mapd: next-cycle check failed");
`else
`define MAPD_ASSERT_SAME(label, clk, rst, ante, cons)
`define MAPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/mapd_pkg.sv =====
// ---------------------------------------------------------------------------
// Moving average presence detector package
// Sizes, register codes and the structs passed between the detector modules.
// ---------------------------------------------------------------------------
package mapd_pkg;

   // window and warm-up sizing
   localparam int WINDOW = 16;
   localparam int WARMUP = 100;

   // field widths
   localparam int DIST_W = 12;
   localparam int PCT_W  = 7;
   localparam int MODE_W = 3;

   // derived widths
   localparam int SUM_W = DIST_W + $clog2(WINDOW);
   localparam int CNT_W = (WARMUP > 0) ? $clog2(WARMUP + 1) : 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIST_W;

   // percent scale of the dead band
   localparam int PERCENT_SCALE = 100;

   // detection tests
   typedef enum logic [MODE_W-1:0] {
      MODE_BASIC      = 3'd0,
      MODE_BASIC_MEAN = 3'd1,
      MODE_SMART      = 3'd2,
      MODE_SMART_MEAN = 3'd3,
      MODE_PERCENT    = 3'd4,
      MODE_FIXED      = 3'd5
   } mode_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE          = 3'd0,
      CSR_THRESHOLD     = 3'd1,
      CSR_NORMAL        = 3'd2,
      CSR_DEV_PERCENT   = 3'd3,
      CSR_DEV_FIXED     = 3'd4
   } csr_index_type;

   // configuration seen by the test logic
   typedef struct packed {
      mode_type           mode;
      logic [DIST_W-1:0]  threshold_distance;
      logic [DIST_W-1:0]  normal_distance;
      logic [PCT_W-1:0]   band_percent;
      logic [DIST_W-1:0]  deviation_fixed;
   } cfg_type;

   // item after the window update
   typedef struct packed {
      logic [DIST_W-1:0] sample;
      logic [DIST_W-1:0] mean;
      logic              primed;
   } stage_type;

endpackage

// ===== rtl/core/mapd_req_if.sv =====
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one distance sample per item.
// ---------------------------------------------------------------------------
interface mapd_req_if;
   logic                         valid;
   logic                         ready;
   logic [mapd_pkg::DIST_W-1:0]  distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

// ===== rtl/core/mapd_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying detection flag, primed flag and mean distance.
// ---------------------------------------------------------------------------
interface mapd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         detected;
   logic                         primed;
   logic [mapd_pkg::DIST_W-1:0]  mean_distance;

   modport source (output valid, output detected, output primed, output mean_distance,
                   input ready);
   modport sink   (input valid, input detected, input primed, input mean_distance,
                   output ready);
endinterface

// ===== rtl/core/mapd_csr_if.sv =====
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface mapd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mapd_pkg::CSR_IDX_W-1:0]   index;
   logic [mapd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mapd_csr.sv =====
// ---------------------------------------------------------------------------
// Detector configuration registers
// Decodes register writes into the test settings; always ready.
// ---------------------------------------------------------------------------
module mapd_csr (
   input  logic                  clock,
   input  logic                  reset,
   mapd_csr_if.sink              csr,
   output mapd_pkg::cfg_type     cfg
);

   mapd_pkg::cfg_type cfg_ff;
   mapd_pkg::cfg_type cfg_in;
   logic              write;

   assign csr.ready = 1'b1;
   assign write     = csr.valid && csr.ready;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr.index)
            mapd_pkg::CSR_MODE:
               cfg_in.mode = mapd_pkg::mode_type'(csr.data[mapd_pkg::MODE_W-1:0]);
            mapd_pkg::CSR_THRESHOLD:
               cfg_in.threshold_distance = csr.data[mapd_pkg::DIST_W-1:0];
            mapd_pkg::CSR_NORMAL:
               cfg_in.normal_distance = csr.data[mapd_pkg::DIST_W-1:0];
            mapd_pkg::CSR_DEV_PERCENT:
               cfg_in.band_percent = csr.data[mapd_pkg::PCT_W-1:0];
            mapd_pkg::CSR_DEV_FIXED:
               cfg_in.deviation_fixed = csr.data[mapd_pkg::DIST_W-1:0];
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/mapd_window.sv =====
// ---------------------------------------------------------------------------
// Sample window and running sum
// Shifts each accepted sample into the window, updates the running sum,
// counts warm-up samples and registers sample, mean and primed flag.
// ---------------------------------------------------------------------------
`include "moving_average_presence_detector_assert.svh"

module mapd_window (
   input  logic                  clock,
   input  logic                  reset,
   mapd_req_if.sink              req,
   output logic                  stage_valid,
   input  logic                  stage_ready,
   output mapd_pkg::stage_type   stage
);

   logic [mapd_pkg::DIST_W-1:0] window_ff [mapd_pkg::WINDOW];
   logic [mapd_pkg::DIST_W-1:0] window_in [mapd_pkg::WINDOW];
   logic [mapd_pkg::SUM_W-1:0]  sum_ff;
   logic [mapd_pkg::SUM_W-1:0]  sum_in;
   logic [mapd_pkg::CNT_W-1:0]  count_ff;
   logic [mapd_pkg::CNT_W-1:0]  count_in;
   logic                        stage_valid_ff;
   mapd_pkg::stage_type         stage_ff;
   logic                        accept;
   logic                        primed_now;

   // take a new item whenever the stage register is empty or drains this cycle
   assign req.ready  = !stage_valid_ff || stage_ready;
   assign accept     = req.valid && req.ready;
   assign primed_now = (count_ff == mapd_pkg::CNT_W'(mapd_pkg::WARMUP));

   // window shift and running sum
   always_comb begin
      window_in = window_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      if (accept) begin
         for (int i = 0; i < mapd_pkg::WINDOW - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[mapd_pkg::WINDOW - 1] = req.distance;
         sum_in = sum_ff - mapd_pkg::SUM_W'(window_ff[0])
                         + mapd_pkg::SUM_W'(req.distance);
         if (!primed_now) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // control state and window contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mapd_pkg::WINDOW; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff         <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (stage_ready) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   // stage payload: mean of the updated window
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff.sample <= req.distance;
         stage_ff.mean   <= mapd_pkg::DIST_W'(sum_in / mapd_pkg::WINDOW);
         stage_ff.primed <= primed_now;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

   `MAPD_ASSERT_NEXT(a_warmup_count_step, clock, reset, accept && !primed_now, count_ff == $past(count_ff) + 1'b1)
   `MAPD_ASSERT_NEXT(a_primed_sticky, clock, reset, primed_now, primed_now)
   `MAPD_ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !stage_ready, stage_valid_ff && $stable(stage_ff))

endmodule

// ===== rtl/core/mapd_detect.sv =====
// ---------------------------------------------------------------------------
// Detection test and result register
// Applies the selected test to the sample and mean and holds the result item
// until the consumer takes it.
// ---------------------------------------------------------------------------
`include "moving_average_presence_detector_assert.svh"

module mapd_detect (
   input  logic                  clock,
   input  logic                  reset,
   input  mapd_pkg::cfg_type     cfg,
   input  logic                  stage_valid,
   output logic                  stage_ready,
   input  mapd_pkg::stage_type   stage,
   mapd_rsp_if.source            rsp
);

   localparam int PROD_W = mapd_pkg::DIST_W + mapd_pkg::PCT_W;
   localparam int PBAND_W = PROD_W + 2;
   localparam int FBAND_W = mapd_pkg::DIST_W + 2;

   logic                          rsp_valid_ff;
   logic                          detected_ff;
   logic                          primed_ff;
   logic [mapd_pkg::DIST_W-1:0]   mean_ff;
   logic                          advance;
   logic                          thr_raw;
   logic                          thr_mean;
   logic                          raw_above_mean;
   logic                          above_normal;
   logic [PROD_W-1:0]             pct_scaled;
   logic [PROD_W-1:0]             pct_span;
   logic signed [PBAND_W-1:0]     pct_mid;
   logic signed [PBAND_W-1:0]     pct_lo;
   logic signed [PBAND_W-1:0]     pct_hi;
   logic signed [FBAND_W-1:0]     fix_mid;
   logic signed [FBAND_W-1:0]     fix_lo;
   logic signed [FBAND_W-1:0]     fix_hi;
   logic                          out_pct_band;
   logic                          out_fix_band;
   logic                          test;

   assign advance     = !rsp_valid_ff || rsp.ready;
   assign stage_ready = advance;

   // basic comparisons
   assign thr_raw        = cfg.threshold_distance < stage.sample;
   assign thr_mean       = cfg.threshold_distance < stage.mean;
   assign raw_above_mean = stage.sample > stage.mean;
   assign above_normal   = stage.mean > cfg.normal_distance;

   // percent dead band around the mean, scaled by 100
   assign pct_scaled = PROD_W'(stage.mean) * PROD_W'(mapd_pkg::PERCENT_SCALE);
   assign pct_span   = PROD_W'(stage.mean) * PROD_W'(cfg.band_percent);
   assign pct_mid    = signed'({2'b00, pct_scaled});
   assign pct_lo     = pct_mid - signed'({2'b00, pct_span});
   assign pct_hi     = pct_mid + signed'({2'b00, pct_span});
   assign out_pct_band = (pct_mid < pct_lo) || (pct_mid > pct_hi);

   // fixed dead band around the mean
   assign fix_mid = signed'({2'b00, stage.mean});
   assign fix_lo  = fix_mid - signed'({2'b00, cfg.deviation_fixed});
   assign fix_hi  = fix_mid + signed'({2'b00, cfg.deviation_fixed});
   assign out_fix_band = (fix_mid < fix_lo) || (fix_mid > fix_hi);

   // test select
   always_comb begin
      case (cfg.mode)
         mapd_pkg::MODE_BASIC:      test = thr_raw;
         mapd_pkg::MODE_BASIC_MEAN: test = thr_mean;
         mapd_pkg::MODE_SMART:      test = thr_mean || raw_above_mean;
         mapd_pkg::MODE_SMART_MEAN: test = thr_mean || above_normal;
         mapd_pkg::MODE_PERCENT:    test = out_pct_band || above_normal;
         mapd_pkg::MODE_FIXED:      test = out_fix_band || above_normal;
         default:                   test = 1'b0;
      endcase
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         detected_ff <= stage.primed && test;
         primed_ff   <= stage.primed;
         mean_ff     <= stage.mean;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.detected      = detected_ff;
   assign rsp.primed        = primed_ff;
   assign rsp.mean_distance = mean_ff;

   `MAPD_ASSERT_SAME(a_no_detect_in_warmup, clock, reset, rsp_valid_ff && !primed_ff, !detected_ff)
   `MAPD_ASSERT_NEXT(a_result_loaded, clock, reset, advance && stage_valid, rsp_valid_ff && primed_ff == $past(stage.primed))

endmodule

// ===== rtl/core/moving_average_presence_detector.sv =====
// ---------------------------------------------------------------------------
// Moving average presence detector
// Sixteen-sample moving average of distance samples with a selectable
// presence test and a warm-up period after reset.
// ---------------------------------------------------------------------------
// Accepts one distance sample per cycle while the result channel is not
// stalled and returns one result item per sample, through the window stage
// register and then the result register. The first 100 samples after reset
// only fill the window: their results carry primed=0 and detected=0 but do
// report the mean. The rate is set by the running-sum register, which takes
// one add and one subtract per sample. A stalled result is held in the
// output register while one more sample can still be taken into the window
// stage. Write configuration only while no items are in flight.
module moving_average_presence_detector (
   input  logic      clock,
   input  logic      reset,
   mapd_req_if.sink  req_ch,
   mapd_rsp_if.source rsp_ch,
   mapd_csr_if.sink  csr_ch
);

   mapd_pkg::cfg_type    cfg;
   mapd_pkg::stage_type  stage;
   logic                 stage_valid;
   logic                 stage_ready;

   // configuration registers
   mapd_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // window, running sum and warm-up count
   mapd_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   // test and result register
   mapd_detect u_detect (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage_ready (stage_ready),
      .stage       (stage),
      .rsp         (rsp_ch)
   );

endmodule
